// ----- rtl/sbmq_pkg.sv -----
// shared types, constants and helpers for the shared-buffer multi-queue
package sbmq_pkg;

    // sizing
    localparam int SLOTS      = 64;
    localparam int QUEUES     = 8;
    localparam int DATA_WIDTH = 32;

    // derived widths
    localparam int IDX_W  = $clog2(SLOTS);
    localparam int PTR_W  = IDX_W + 1;
    localparam int QIDX_W = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam int EXT_W  = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;

    // fixed field widths
    localparam int CMD_W  = 2;
    localparam int QID_W  = 3;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;

    // null pointer is coded as SLOTS
    localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(SLOTS);

    // commands
    localparam logic [CMD_W-1:0] CMD_ENQ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEQ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP  = 2'd3;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]        command;
        logic [QID_W-1:0]        queue_id;
        logic signed [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic signed [VAL_W-1:0] data;
    } rsp_t;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic commit;
    } ctrl_t;

    function automatic logic ptr_valid(input logic [PTR_W-1:0] p);
        return p < PTR_W'(SLOTS);
    endfunction

    // low DATA_WIDTH bits of the zero-extended input value
    function automatic logic [DATA_WIDTH-1:0] store_val(input logic [VAL_W-1:0] v);
        logic [EXT_W-1:0] z;
        z = EXT_W'(v);
        return z[DATA_WIDTH-1:0];
    endfunction

    // stored value sign-extended, low 32 bits
    function automatic logic [VAL_W-1:0] load_val(input logic [DATA_WIDTH-1:0] s);
        logic [EXT_W-1:0] e;
        e = EXT_W'($signed(s));
        return e[VAL_W-1:0];
    endfunction

endpackage

// ----- rtl/sbmq_ctrl.sv -----
// sequencer: two-step operation control and result valid
module sbmq_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output sbmq_pkg::ctrl_t    cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic out_free;

    // result register can take a new beat
    assign out_free = !out_valid_reg || !rsp_stall;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd.accept = 1'b0;
        cmd.commit = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result valid holds until taken
    assign out_valid_next = cmd.commit | (out_valid_reg & rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = out_valid_reg;

    // no new beat taken while an operation is in flight
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EXEC |-> !cmd.accept)
        else $error("accept while busy");

    // a commit never overwrites a result that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && rsp_stall |-> !cmd.commit)
        else $error("result overwritten");

    // every accepted beat is followed by its execute step
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> state_reg == ST_EXEC && !cmd.accept)
        else $error("accept not followed by execute");

endmodule

// ----- rtl/sbmq_datapath.sv -----
// queue pointers, link and slot memories, result register
module sbmq_datapath
(
    input  logic               clk,
    input  logic               rst_n,
    input  sbmq_pkg::ctrl_t    cmd,
    input  sbmq_pkg::req_t     req,
    output sbmq_pkg::rsp_t     rsp
);

    // pointer state
    logic [sbmq_pkg::PTR_W-1:0] head_reg  [sbmq_pkg::QUEUES];
    logic [sbmq_pkg::PTR_W-1:0] head_next [sbmq_pkg::QUEUES];
    logic [sbmq_pkg::IDX_W-1:0] tail_reg  [sbmq_pkg::QUEUES];
    logic [sbmq_pkg::IDX_W-1:0] tail_next [sbmq_pkg::QUEUES];
    logic [sbmq_pkg::PTR_W-1:0] free_head_reg;
    logic [sbmq_pkg::PTR_W-1:0] free_head_next;
    // slots at and above this count were never taken; their link is index + 1
    logic [sbmq_pkg::PTR_W-1:0] fresh_reg;
    logic [sbmq_pkg::PTR_W-1:0] fresh_next;

    // memories
    logic [sbmq_pkg::PTR_W-1:0]      link_mem [sbmq_pkg::SLOTS];
    logic [sbmq_pkg::DATA_WIDTH-1:0] data_mem [sbmq_pkg::SLOTS];

    // operation registers
    sbmq_pkg::req_t                  op_reg;
    logic                            q_ok_reg;
    logic [sbmq_pkg::PTR_W-1:0]      rd_addr_reg;
    logic [sbmq_pkg::PTR_W-1:0]      link_rd_reg;
    logic [sbmq_pkg::DATA_WIDTH-1:0] data_rd_reg;
    sbmq_pkg::rsp_t                  rsp_reg;
    sbmq_pkg::rsp_t                  rsp_next;

    // accept-side lookup
    logic [sbmq_pkg::QIDX_W-1:0] q_in;
    logic [sbmq_pkg::PTR_W-1:0]  head_in;
    logic [sbmq_pkg::PTR_W-1:0]  rd_addr;
    logic                        q_ok_in;

    // execute-side signals
    logic [sbmq_pkg::QIDX_W-1:0]     q_op;
    logic [sbmq_pkg::PTR_W-1:0]      head_op;
    logic                            head_ok;
    logic [sbmq_pkg::PTR_W-1:0]      link_val;
    logic                            link_we;
    logic [sbmq_pkg::IDX_W-1:0]      link_wa;
    logic [sbmq_pkg::PTR_W-1:0]      link_wd;
    logic                            data_we;
    logic [sbmq_pkg::IDX_W-1:0]      data_wa;
    logic [sbmq_pkg::DATA_WIDTH-1:0] data_wd;

    // link read address: free-list head for enqueue, queue head otherwise
    assign q_in    = req.queue_id[sbmq_pkg::QIDX_W-1:0];
    assign head_in = head_reg[q_in];
    assign q_ok_in = int'(req.queue_id) < sbmq_pkg::QUEUES;
    assign rd_addr = (req.command == sbmq_pkg::CMD_ENQ) ? free_head_reg : head_in;

    // link value, corrected for never-taken slots
    assign link_val = (rd_addr_reg >= fresh_reg)
                    ? sbmq_pkg::PTR_W'(rd_addr_reg + 1'b1) : link_rd_reg;

    assign q_op    = op_reg.queue_id[sbmq_pkg::QIDX_W-1:0];
    assign head_op = head_reg[q_op];
    assign head_ok = q_ok_reg && sbmq_pkg::ptr_valid(head_op);

    // execute step
    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        free_head_next = free_head_reg;
        fresh_next     = fresh_reg;
        link_we        = 1'b0;
        link_wa        = free_head_reg[sbmq_pkg::IDX_W-1:0];
        link_wd        = free_head_reg;
        data_we        = 1'b0;
        data_wa        = free_head_reg[sbmq_pkg::IDX_W-1:0];
        data_wd        = sbmq_pkg::store_val(op_reg.value);
        rsp_next       = rsp_reg;
        if (cmd.commit)
        begin
            rsp_next.status = sbmq_pkg::STAT_OK;
            rsp_next.data   = '0;
            unique case (op_reg.command)
                sbmq_pkg::CMD_ENQ:
                begin
                    if (!q_ok_reg || !sbmq_pkg::ptr_valid(free_head_reg))
                    begin
                        rsp_next.status = sbmq_pkg::STAT_FULL;
                    end
                    else
                    begin
                        free_head_next = link_val;
                        if (free_head_reg == fresh_reg)
                        begin
                            fresh_next = sbmq_pkg::PTR_W'(fresh_reg + 1'b1);
                        end
                        if (!head_ok)
                        begin
                            head_next[q_op] = free_head_reg;
                        end
                        else
                        begin
                            // chain behind the current tail
                            link_we = 1'b1;
                            link_wa = tail_reg[q_op];
                            link_wd = free_head_reg;
                        end
                        tail_next[q_op] = free_head_reg[sbmq_pkg::IDX_W-1:0];
                        data_we         = 1'b1;
                    end
                end
                sbmq_pkg::CMD_DEQ:
                begin
                    if (!head_ok)
                    begin
                        rsp_next.status = sbmq_pkg::STAT_EMPTY;
                    end
                    else
                    begin
                        rsp_next.data = sbmq_pkg::load_val(data_rd_reg);
                        // last element ends the chain
                        if (head_op[sbmq_pkg::IDX_W-1:0] == tail_reg[q_op])
                        begin
                            head_next[q_op] = sbmq_pkg::NULL_PTR;
                        end
                        else
                        begin
                            head_next[q_op] = link_val;
                        end
                        // slot back to the front of the free list
                        link_we        = 1'b1;
                        link_wa        = head_op[sbmq_pkg::IDX_W-1:0];
                        link_wd        = free_head_reg;
                        free_head_next = head_op;
                    end
                end
                sbmq_pkg::CMD_PEEK:
                begin
                    if (!head_ok)
                    begin
                        rsp_next.status = sbmq_pkg::STAT_EMPTY;
                    end
                    else
                    begin
                        rsp_next.data = sbmq_pkg::load_val(data_rd_reg);
                    end
                end
                sbmq_pkg::CMD_NOP:
                begin
                    rsp_next.status = sbmq_pkg::STAT_OK;
                end
                default:
                begin
                    rsp_next.status = sbmq_pkg::STAT_OK;
                end
            endcase
        end
    end

    // pointer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sbmq_pkg::QUEUES; i++)
            begin
                head_reg[i] <= sbmq_pkg::NULL_PTR;
                tail_reg[i] <= '0;
            end
            free_head_reg <= '0;
            fresh_reg     <= '0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            free_head_reg <= free_head_next;
            fresh_reg     <= fresh_next;
        end
    end

    // memories with registered reads, operation capture, result register
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_wa] <= link_wd;
        end
        if (data_we)
        begin
            data_mem[data_wa] <= data_wd;
        end
        if (cmd.accept)
        begin
            op_reg      <= req;
            q_ok_reg    <= q_ok_in;
            rd_addr_reg <= rd_addr;
            link_rd_reg <= link_mem[rd_addr[sbmq_pkg::IDX_W-1:0]];
            data_rd_reg <= data_mem[head_in[sbmq_pkg::IDX_W-1:0]];
        end
        rsp_reg <= rsp_next;
    end

    assign rsp = rsp_reg;

    // free list never runs ahead of the untouched region
    a_free_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        free_head_reg <= fresh_reg)
        else $error("free head beyond untouched region");

    // untouched region only grows, one slot at a time and only on an enqueue
    a_fresh_step: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg != fresh_next |-> cmd.commit && op_reg.command == sbmq_pkg::CMD_ENQ
            && fresh_next == sbmq_pkg::PTR_W'(fresh_reg + 1'b1))
        else $error("bad untouched-region step");

    // a successful enqueue leaves its queue non-empty
    a_enq_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && op_reg.command == sbmq_pkg::CMD_ENQ
            && rsp_next.status == sbmq_pkg::STAT_OK
        |=> sbmq_pkg::ptr_valid(head_reg[$past(q_op)]))
        else $error("queue empty after enqueue");

endmodule

// ----- rtl/shared_buffer_multi_queue_core.sv -----
// top level of the shared-buffer multi-queue
//
// Eight FIFO queues share one store of 64 slots chained through a link
// memory; unused slots sit on a free list. One request beat (command,
// queue number, value) gives exactly one response beat (status, data).
// Enqueue answers full when no slot is free; dequeue and peek answer
// empty on an empty queue and otherwise return the head value.
//
// Both channels use valid/stall; a beat moves when valid is high and
// stall is low. A request has a read step for the link and slot memories
// (synchronous read port), then an execute step that updates the pointers
// and writes back. The response is registered and shows in the cycle after
// the execute step; req_stall is high until that step is done.
// While a response is stalled, the next request is captured and read but
// waits in its execute step; req_stall stays high meanwhile.
// Reset empties every queue and chains all slots onto the free list at
// once, with no clearing pass; the block takes a request right after reset.
module shared_buffer_multi_queue_core
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  sbmq_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output sbmq_pkg::rsp_t  rsp
);

    sbmq_pkg::ctrl_t cmd;

    sbmq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd)
    );

    sbmq_datapath u_datapath
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

// ----- tb/shared_buffer_multi_queue_core_tb.sv -----
// self-checking testbench for the shared-buffer multi-queue core
`timescale 1ns / 1ps

module shared_buffer_multi_queue_core_tb;

    localparam int HALF_PERIOD = 6;
    localparam int RESET_CYCLES = 10;
    localparam int RANDOM_OPS = 1630;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        sbmq_pkg::req_t beat;
        bit             wait_idle;
    } req_entry_t;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_e;

    typedef enum int {
        PH_FILL,
        PH_DRAIN,
        PH_MIXED,
        PH_NARROW
    } phase_e;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    sbmq_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    sbmq_pkg::rsp_t rsp;

    // stimulus and expected responses
    req_entry_t req_backlog[$];
    sbmq_pkg::rsp_t awaited_rsp[$];
    int error_count = 0;
    int rsp_count = 0;
    bit req_fire = 1'b0;

    // shadow copy of the queue structure
    logic [sbmq_pkg::DATA_WIDTH-1:0] value_mem [sbmq_pkg::SLOTS];
    logic [sbmq_pkg::PTR_W-1:0] link_mem [sbmq_pkg::SLOTS];
    logic [sbmq_pkg::PTR_W-1:0] head_ptr [sbmq_pkg::QUEUES];
    logic [sbmq_pkg::PTR_W-1:0] tail_ptr [sbmq_pkg::QUEUES];
    logic [sbmq_pkg::PTR_W-1:0] free_ptr;

    // sender burst state
    int burst_left = 4;
    int gap_left = 0;
    req_entry_t next_entry;

    // receiver stall state
    stall_mode_e stall_mode = STALL_NONE;
    int stall_cycle = 0;

    shared_buffer_multi_queue_core uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #HALF_PERIOD clk = ~clk;

    // apply one operation to the shadow structure and return its response
    function automatic sbmq_pkg::rsp_t apply_queue_op(input sbmq_pkg::req_t op);
        sbmq_pkg::rsp_t res;
        logic [sbmq_pkg::PTR_W-1:0] slot;
        res.status = sbmq_pkg::STAT_OK;
        res.data = '0;
        case (op.command)
            sbmq_pkg::CMD_ENQ:
            begin
                if (op.queue_id >= sbmq_pkg::QUEUES || free_ptr >= sbmq_pkg::SLOTS)
                begin
                    res.status = sbmq_pkg::STAT_FULL;
                end
                else
                begin
                    slot = free_ptr;
                    free_ptr = link_mem[slot[sbmq_pkg::IDX_W-1:0]];
                    // a drained queue ignores its stale tail
                    if (head_ptr[op.queue_id] >= sbmq_pkg::SLOTS)
                        head_ptr[op.queue_id] = slot;
                    else if (tail_ptr[op.queue_id] < sbmq_pkg::SLOTS)
                        link_mem[tail_ptr[op.queue_id][sbmq_pkg::IDX_W-1:0]] = slot;
                    link_mem[slot[sbmq_pkg::IDX_W-1:0]] = sbmq_pkg::NULL_PTR;
                    tail_ptr[op.queue_id] = slot;
                    value_mem[slot[sbmq_pkg::IDX_W-1:0]] =
                        sbmq_pkg::DATA_WIDTH'($unsigned(op.value));
                end
            end
            sbmq_pkg::CMD_DEQ:
            begin
                if (op.queue_id >= sbmq_pkg::QUEUES
                    || head_ptr[op.queue_id] >= sbmq_pkg::SLOTS)
                begin
                    res.status = sbmq_pkg::STAT_EMPTY;
                end
                else
                begin
                    slot = head_ptr[op.queue_id];
                    res.data = sbmq_pkg::VAL_W'($signed(
                        value_mem[slot[sbmq_pkg::IDX_W-1:0]]));
                    head_ptr[op.queue_id] = link_mem[slot[sbmq_pkg::IDX_W-1:0]];
                    link_mem[slot[sbmq_pkg::IDX_W-1:0]] = free_ptr;
                    free_ptr = slot;
                end
            end
            sbmq_pkg::CMD_PEEK:
            begin
                if (op.queue_id >= sbmq_pkg::QUEUES
                    || head_ptr[op.queue_id] >= sbmq_pkg::SLOTS)
                    res.status = sbmq_pkg::STAT_EMPTY;
                else
                    res.data = sbmq_pkg::VAL_W'($signed(
                        value_mem[head_ptr[op.queue_id][sbmq_pkg::IDX_W-1:0]]));
            end
            default:
            begin
                // unknown command changes nothing
            end
        endcase
        return res;
    endfunction

    task automatic push_op(input logic [sbmq_pkg::CMD_W-1:0] cmd, input int qid,
                           input logic [sbmq_pkg::VAL_W-1:0] val, input bit wait_idle);
        req_entry_t e;
        e.beat.command = cmd;
        e.beat.queue_id = sbmq_pkg::QID_W'(qid);
        e.beat.value = val;
        e.wait_idle = wait_idle;
        req_backlog.push_back(e);
    endtask

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t: %s", $time, msg);
    endtask

    // request sender: bursts with random gaps, optional hold until idle
    always @(negedge clk)
    begin
        if (rst_n && (!req_valid || req_fire))
        begin
            if (gap_left != 0)
            begin
                gap_left--;
                req_valid <= 1'b0;
            end
            else if (req_backlog.size() != 0 &&
                     !(req_backlog[0].wait_idle && awaited_rsp.size() != 0))
            begin
                next_entry = req_backlog.pop_front();
                req <= next_entry.beat;
                req_valid <= 1'b1;
                if (burst_left > 1)
                begin
                    burst_left--;
                end
                else
                begin
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                             : $urandom_range(1, 8);
                end
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // response receiver: stall pattern drawn at random from the stall modes
    always @(negedge clk)
    begin
        stall_cycle++;
        if (stall_cycle % 256 == 0)
            stall_mode <= stall_mode_e'($urandom_range(0, 3));
        case (stall_mode)
            STALL_NONE:     rsp_stall <= 1'b0;
            STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 9) < 3);
            STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 9) < 7);
            STALL_PERIODIC: rsp_stall <= (stall_cycle % 8 < 5);
            default:        rsp_stall <= 1'b0;
        endcase
    end

    // monitor: predict on request beats, check response beats
    always @(posedge clk)
    begin
        req_fire = rst_n && req_valid && !req_stall;
        if (req_fire)
            awaited_rsp.push_back(apply_queue_op(req));
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            rsp_count++;
            if (awaited_rsp.size() == 0)
            begin
                note_error($sformatf("response %0d with none expected: status %0d data %h",
                                     rsp_count, rsp.status, rsp.data));
            end
            else
            begin
                if (rsp.status !== awaited_rsp[0].status)
                    note_error($sformatf("response %0d status: expected %0d, got %0d",
                                         rsp_count, awaited_rsp[0].status, rsp.status));
                if (rsp.data !== awaited_rsp[0].data)
                    note_error($sformatf("response %0d data: expected %h, got %h",
                                         rsp_count, awaited_rsp[0].data, rsp.data));
                void'(awaited_rsp.pop_front());
            end
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        int n_ops;
        int len;
        int roll;
        int qid;
        bit hold;
        bit first;
        phase_e ph;
        logic [sbmq_pkg::CMD_W-1:0] cmd;
        logic [sbmq_pkg::VAL_W-1:0] val;

        // shadow structure after reset
        for (int i = 0; i < sbmq_pkg::SLOTS; i++)
        begin
            value_mem[i] = '0;
            link_mem[i] = sbmq_pkg::PTR_W'(i + 1);
        end
        link_mem[sbmq_pkg::SLOTS-1] = sbmq_pkg::NULL_PTR;
        for (int i = 0; i < sbmq_pkg::QUEUES; i++)
        begin
            head_ptr[i] = sbmq_pkg::NULL_PTR;
            tail_ptr[i] = '0;
        end
        free_ptr = '0;

        // directed: empty queues, no-op command, value extremes, stale tail
        push_op(sbmq_pkg::CMD_PEEK, 0, 32'h0000_0000, 1'b0);
        push_op(sbmq_pkg::CMD_DEQ,  7, 32'h1234_5678, 1'b0);
        push_op(sbmq_pkg::CMD_NOP,  5, 32'hFFFF_FFFF, 1'b0);
        push_op(sbmq_pkg::CMD_ENQ,  0, 32'h8000_0000, 1'b0);
        push_op(sbmq_pkg::CMD_ENQ,  0, 32'h7FFF_FFFF, 1'b0);
        push_op(sbmq_pkg::CMD_ENQ,  7, 32'hFFFF_FFFF, 1'b0);
        push_op(sbmq_pkg::CMD_ENQ,  3, 32'h0000_0000, 1'b0);
        push_op(sbmq_pkg::CMD_PEEK, 0, 32'hFFFF_FFFF, 1'b0);
        push_op(sbmq_pkg::CMD_DEQ,  0, 32'h0000_0000, 1'b0);
        push_op(sbmq_pkg::CMD_DEQ,  0, 32'h0000_0000, 1'b0);
        push_op(sbmq_pkg::CMD_DEQ,  0, 32'h0000_0000, 1'b0);
        push_op(sbmq_pkg::CMD_PEEK, 0, 32'h0000_0000, 1'b0);
        push_op(sbmq_pkg::CMD_ENQ,  0, 32'h5A5A_5A5A, 1'b0);
        push_op(sbmq_pkg::CMD_ENQ,  0, 32'hA5A5_A5A5, 1'b0);
        push_op(sbmq_pkg::CMD_DEQ,  0, 32'h0000_0000, 1'b0);
        push_op(sbmq_pkg::CMD_PEEK, 0, 32'h0000_0000, 1'b0);
        push_op(sbmq_pkg::CMD_DEQ,  7, 32'h0000_0000, 1'b0);
        push_op(sbmq_pkg::CMD_DEQ,  3, 32'h0000_0000, 1'b0);
        push_op(sbmq_pkg::CMD_NOP,  2, 32'h0000_0000, 1'b1);
        push_op(sbmq_pkg::CMD_PEEK, 6, 32'h0000_0000, 1'b0);

        // random phases: filling ones run into full, draining ones into empty
        n_ops = 0;
        first = 1'b1;
        while (n_ops < RANDOM_OPS)
        begin
            ph = phase_e'($urandom_range(0, 3));
            len = $urandom_range(30, 150);
            hold = first || ($urandom_range(0, 2) == 0);
            first = 1'b0;
            for (int k = 0; k < len && n_ops < RANDOM_OPS; k++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 4)
                    cmd = sbmq_pkg::CMD_NOP;
                else
                begin
                    case (ph)
                        PH_FILL:
                            cmd = (roll < 80) ? sbmq_pkg::CMD_ENQ
                                : (roll < 92) ? sbmq_pkg::CMD_DEQ : sbmq_pkg::CMD_PEEK;
                        PH_DRAIN:
                            cmd = (roll < 20) ? sbmq_pkg::CMD_ENQ
                                : (roll < 85) ? sbmq_pkg::CMD_DEQ : sbmq_pkg::CMD_PEEK;
                        default:
                            cmd = (roll < 45) ? sbmq_pkg::CMD_ENQ
                                : (roll < 80) ? sbmq_pkg::CMD_DEQ : sbmq_pkg::CMD_PEEK;
                    endcase
                end
                qid = (ph == PH_NARROW) ? $urandom_range(0, 1)
                                        : $urandom_range(0, (1 << sbmq_pkg::QID_W) - 1);
                case ($urandom_range(0, 15))
                    0:       val = 32'h8000_0000;
                    1:       val = 32'h7FFF_FFFF;
                    2:       val = 32'hFFFF_FFFF;
                    3:       val = 32'h0000_0000;
                    default: val = $urandom();
                endcase
                push_op(cmd, qid, val, hold && k == 0);
                n_ops++;
            end
        end

        // reset, released on a falling edge
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // wait for every request to go in and every response to come out
        while (req_backlog.size() != 0 || req_valid)
            @(negedge clk);
        while (awaited_rsp.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (awaited_rsp.size() != 0)
            note_error($sformatf("%0d responses never arrived", awaited_rsp.size()));

        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // run limit
    initial
    begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
